FILE: sv/crs_pkg.sv
// crs_pkg: shared constants, status codes and result type of the record checker
// no dependencies; used by every module of crc_record_stream_checker
`default_nettype none

package crs_pkg;

    localparam int LENGTH_BITS = 16;
    localparam int HDR_POS_BITS = 4;
    localparam int MAGIC_BITS = 32;
    localparam int CRC_BITS = 16;
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [CRC_BITS-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_BITS-1:0] CRC_POLY = 16'h1021;

    // header byte positions
    localparam logic [HDR_POS_BITS-1:0] POS_MAGIC_END = 4'd4;
    localparam logic [HDR_POS_BITS-1:0] POS_MAGIC_LAST = 4'd3;
    localparam logic [HDR_POS_BITS-1:0] POS_LENGTH_END = 4'd8;
    localparam logic [HDR_POS_BITS-1:0] POS_LENGTH_LAST = 4'd7;
    localparam logic [HDR_POS_BITS-1:0] CRC_HDR_BYTES = 4'd10;
    localparam logic [HDR_POS_BITS-1:0] POS_CHECK_LAST = 4'd11;
    localparam logic [HDR_POS_BITS-1:0] HDR_BYTES = 4'd12;

    // status codes
    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_INTEGRITY = 2'd1;
    localparam logic [1:0] STATUS_RANGE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_RECORD_MAGIC = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_LENGTH = 1'b1;

    typedef struct packed {
        logic                   has_data;
        logic [7:0]             data_byte;
        logic                   done_res;
        logic [1:0]             status;
        logic [LENGTH_BITS-1:0] record_length;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/crc_record_stream_checker.sv
// crc_record_stream_checker: top level with input register, config registers and result register
// depends on crs_pkg and crs_core
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------------------
//  in       | sink      | in_valid / in_stall  | start_req, value
//  out      | source    | out_valid / out_stall| has_data, data_byte, done_res, status,
//           |           |                      | record_length
//  cfg      | sink      | cfg_write            | cfg_index, cfg_data
//
//  one byte request per cycle while in_stall is low; a result passes through the input register,
//  then the crc/header decision into the result register
//  reset clears the record state to idle; bytes are ignored until a start_req
//  out_stall holds the result register and, while it is full, the input register
//  in_stall rises only when both registers are full and the output is stalled
`default_nettype none

module crc_record_stream_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                start_req,
    input  wire logic [7:0]                          value,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     has_data,
    output logic [7:0]                               data_byte,
    output logic                                     done_res,
    output logic [1:0]                               status,
    output logic [crs_pkg::LENGTH_BITS-1:0]          record_length,
    input  wire logic                                cfg_write,
    input  wire logic [crs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [crs_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    logic                                 in_valid_reg;
    logic                                 start_reg;
    logic [7:0]                           value_reg;
    logic                                 out_valid_reg;
    crs_pkg::result_t                     result_reg;
    logic [crs_pkg::MAGIC_BITS-1:0]       record_magic_reg;
    logic [crs_pkg::LENGTH_BITS-1:0]      max_length_reg;

    logic                                 out_free;
    logic                                 produce;
    crs_pkg::result_t                     result_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = in_valid_reg && !out_free;

    crs_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (in_valid_reg && out_free),
        .start_req    (start_reg),
        .value        (value_reg),
        .record_magic (record_magic_reg),
        .max_length   (max_length_reg),
        .produce      (produce),
        .result       (result_next)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            start_reg <= start_req;
            value_reg <= value;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && in_valid_reg && produce)
        begin
            result_reg <= result_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            record_magic_reg <= '0;
            max_length_reg   <= '1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                crs_pkg::REG_RECORD_MAGIC:
                begin
                    record_magic_reg <= cfg_data[crs_pkg::MAGIC_BITS-1:0];
                end
                crs_pkg::REG_MAX_LENGTH:
                begin
                    max_length_reg <= cfg_data[crs_pkg::LENGTH_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign has_data      = result_reg.has_data;
    assign data_byte     = result_reg.data_byte;
    assign done_res      = result_reg.done_res;
    assign status        = result_reg.status;
    assign record_length = result_reg.record_length;

endmodule

`default_nettype wire

FILE: sv/crs_crc_step.sv
// crs_crc_step: one byte of CRC-16/CCITT-FALSE (poly 0x1021), unrolled xor logic
// depends on crs_pkg
`default_nettype none

module crs_crc_step (
    input  wire logic [crs_pkg::CRC_BITS-1:0] crc_in,
    input  wire logic [7:0]                   data_in,
    output logic      [crs_pkg::CRC_BITS-1:0] crc_out
);

    always_comb
    begin
        logic [crs_pkg::CRC_BITS-1:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (c[crs_pkg::CRC_BITS-1])
            begin
                c = {c[crs_pkg::CRC_BITS-2:0], 1'b0} ^ crs_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[crs_pkg::CRC_BITS-2:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

FILE: sv/crs_core.sv
// crs_core: record state (position, header fields, running crc) and result decision
// depends on crs_pkg and crs_crc_step
`default_nettype none

module crs_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                fire,
    input  wire logic                                start_req,
    input  wire logic [7:0]                          value,
    input  wire logic [crs_pkg::MAGIC_BITS-1:0]      record_magic,
    input  wire logic [crs_pkg::LENGTH_BITS-1:0]     max_length,
    output logic                                     produce,
    output crs_pkg::result_t                         result
);

    localparam int LB = crs_pkg::LENGTH_BITS;

    logic [crs_pkg::HDR_POS_BITS-1:0] hdr_pos_reg, hdr_pos_next;
    logic [LB-1:0]                    data_count_reg, data_count_next;
    logic [crs_pkg::MAGIC_BITS-1:0]   magic_shift_reg, magic_shift_next;
    logic [31:0]                      stored_len_reg, stored_len_next;
    logic [crs_pkg::CRC_BITS-1:0]     stored_check_reg, stored_check_next;
    logic [crs_pkg::CRC_BITS-1:0]     crc_reg, crc_next;
    logic                             finished_reg, finished_next;

    logic [crs_pkg::HDR_POS_BITS-1:0] base_pos;
    logic [LB-1:0]                    base_count;
    logic [crs_pkg::MAGIC_BITS-1:0]   base_magic;
    logic [31:0]                      base_len;
    logic [crs_pkg::CRC_BITS-1:0]     base_check;
    logic [crs_pkg::CRC_BITS-1:0]     base_crc;
    logic [crs_pkg::CRC_BITS-1:0]     crc_stepped;
    logic [LB:0]                      count_plus;
    logic                             active;

    crs_crc_step u_crc_step (
        .crc_in  (base_crc),
        .data_in (value),
        .crc_out (crc_stepped)
    );

    always_comb
    begin
        base_pos   = start_req ? '0 : hdr_pos_reg;
        base_count = start_req ? '0 : data_count_reg;
        base_magic = start_req ? '0 : magic_shift_reg;
        base_len   = start_req ? '0 : stored_len_reg;
        base_check = start_req ? '0 : stored_check_reg;
        base_crc   = start_req ? crs_pkg::CRC_INIT : crc_reg;
        count_plus = {1'b0, base_count} + 1'b1;
        active     = fire && (start_req || !finished_reg);

        hdr_pos_next      = hdr_pos_reg;
        data_count_next   = data_count_reg;
        magic_shift_next  = magic_shift_reg;
        stored_len_next   = stored_len_reg;
        stored_check_next = stored_check_reg;
        crc_next          = crc_reg;
        finished_next     = finished_reg;
        produce           = 1'b0;
        result            = '0;

        if (active)
        begin
            hdr_pos_next      = base_pos;
            data_count_next   = base_count;
            magic_shift_next  = base_magic;
            stored_len_next   = base_len;
            stored_check_next = base_check;
            crc_next          = base_crc;
            finished_next     = 1'b0;

            if (base_pos < crs_pkg::HDR_BYTES)
            begin
                hdr_pos_next = base_pos + 1'b1;
            end
            if (base_pos < crs_pkg::CRC_HDR_BYTES)
            begin
                crc_next = crc_stepped;
            end

            if (base_pos < crs_pkg::POS_MAGIC_END)
            begin
                magic_shift_next = {base_magic[crs_pkg::MAGIC_BITS-9:0], value};
                if (base_pos == crs_pkg::POS_MAGIC_LAST && magic_shift_next != record_magic)
                begin
                    finished_next = 1'b1;
                    produce       = 1'b1;
                    result.done_res = 1'b1;
                    result.status   = crs_pkg::STATUS_INTEGRITY;
                end
            end
            else if (base_pos < crs_pkg::POS_LENGTH_END)
            begin
                stored_len_next = {base_len[23:0], value};
                if (base_pos == crs_pkg::POS_LENGTH_LAST && stored_len_next > 32'(max_length))
                begin
                    finished_next = 1'b1;
                    produce       = 1'b1;
                    result.done_res = 1'b1;
                    result.status   = crs_pkg::STATUS_RANGE;
                end
            end
            else if (base_pos < crs_pkg::CRC_HDR_BYTES)
            begin
                // sequence number, covered by crc only
            end
            else if (base_pos < crs_pkg::HDR_BYTES)
            begin
                stored_check_next = {base_check[7:0], value};
                // empty record ends on the last header byte
                if (base_pos == crs_pkg::POS_CHECK_LAST && base_len == '0)
                begin
                    finished_next   = 1'b1;
                    produce         = 1'b1;
                    result.done_res = 1'b1;
                    if (base_crc == stored_check_next)
                    begin
                        result.status        = crs_pkg::STATUS_OK;
                        result.record_length = base_len[LB-1:0];
                    end
                    else
                    begin
                        result.status = crs_pkg::STATUS_INTEGRITY;
                    end
                end
            end
            else
            begin
                crc_next         = crc_stepped;
                data_count_next  = count_plus[LB-1:0];
                produce          = 1'b1;
                result.has_data  = 1'b1;
                result.data_byte = value;
                if (count_plus == {1'b0, base_len[LB-1:0]})
                begin
                    finished_next   = 1'b1;
                    result.done_res = 1'b1;
                    if (crc_stepped == base_check)
                    begin
                        result.status        = crs_pkg::STATUS_OK;
                        result.record_length = base_len[LB-1:0];
                    end
                    else
                    begin
                        result.status = crs_pkg::STATUS_INTEGRITY;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg      <= '0;
            data_count_reg   <= '0;
            magic_shift_reg  <= '0;
            stored_len_reg   <= '0;
            stored_check_reg <= '0;
            crc_reg          <= crs_pkg::CRC_INIT;
            finished_reg     <= 1'b1;
        end
        else
        begin
            hdr_pos_reg      <= hdr_pos_next;
            data_count_reg   <= data_count_next;
            magic_shift_reg  <= magic_shift_next;
            stored_len_reg   <= stored_len_next;
            stored_check_reg <= stored_check_next;
            crc_reg          <= crc_next;
            finished_reg     <= finished_next;
        end
    end

endmodule

`default_nettype wire
